[src/plqm_pkg.sv]
`default_nettype none
package plqm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEND_PERIOD = 2'd0;
  localparam logic [1:0] CFG_WAIT_WINDOW = 2'd1;
  localparam logic [1:0] CFG_MAGIC       = 2'd2;

  // Item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_REPLY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Register reset values and fixed constants
  localparam logic [15:0] PERIOD_RESET = 16'd550;
  localparam logic [9:0]  WINDOW_RESET = 10'd80;
  localparam logic [7:0]  MAGIC_RESET  = 8'hB4;
  localparam logic [7:0]  REPLY_KIND   = 8'd2;
  localparam logic [6:0]  PCT_SCALE    = 7'd100;
  localparam logic [15:0] SINCE_SAT    = 16'hFFFF;
  localparam logic [31:0] CNT_SAT      = 32'hFFFF_FFFF;

  // Dividend ok*100 spans 39 bits
  localparam int unsigned DIVIDEND_W = 39;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic [6:0]  quality_pct;
    logic [9:0]  latency_best;
    logic [9:0]  latency_last;
    logic [31:0] ok_total;
    logic [31:0] sent_total;
    logic        waiting;
    logic        reply_ok;
    logic [31:0] ping_uptime;
    logic [15:0] ping_seq;
    logic        ping_send;
  } plqm_result_t;

endpackage
`default_nettype wire

[src/ping_link_quality_monitor_unit.sv]
`default_nettype none
// Ping link quality monitor, master side. Each input transfer is a tick, a
// received reply or a clear command (opcode on in_tuser); each produces one
// result transfer with the ping issued, the reply verdict and the running
// statistics. The monitor state updates at the accepting edge. After
// acceptance, a load state forms ok*100, a bit-serial restoring divider
// shifts in one dividend bit per cycle to produce quality_pct, and a done
// state loads the output register. One item is in work at a time; the next
// is accepted as soon as the previous result sits in the output register,
// and a stalled result holds off the next item.
module ping_link_quality_monitor_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata fields from bit 0: reply_magic[7:0], reply_kind[7:0], reply_seq[15:0]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  // in_tuser fields from bit 0: opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  // out_tdata fields from bit 0: ping_send, ping_seq[15:0], ping_uptime[31:0],
  // reply_ok, waiting, sent_total[31:0], ok_total[31:0], latency_last[9:0],
  // latency_best[9:0], quality_pct[6:0], two zero pad bits
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [143:0]     out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import plqm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;
  localparam logic [5:0] DIV_LAST = 6'(DIVIDEND_W - 1);

  logic [1:0]  state_r, state_nxt;

  // Configuration registers
  logic [15:0] period_r;
  logic [9:0]  window_r;
  logic [7:0]  magic_r;

  // Monitor state
  logic [31:0] uptime_r, uptime_nxt;
  logic [15:0] since_r, since_nxt;
  logic        open_r, open_nxt;
  logic [9:0]  elapsed_r, elapsed_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] acc_seq_r, acc_seq_nxt;
  logic [31:0] sent_r, sent_nxt;
  logic [31:0] ok_r, ok_nxt;
  logic [9:0]  lat_last_r, lat_last_nxt;
  logic [9:0]  lat_best_r, lat_best_nxt;

  // Per-item results held while the divider runs
  logic        send_r, send_nxt;
  logic [15:0] pseq_r, pseq_nxt;
  logic [31:0] pup_r, pup_nxt;
  logic        rok_r, rok_nxt;

  // Divider
  logic [DIVIDEND_W-1:0] num_r;
  logic [31:0] rem_r;
  logic [6:0]  quo_r;
  logic        ovf_r;
  logic [5:0]  cnt_r;
  logic [32:0] rem_shift;
  logic [32:0] rem_diff;
  logic        quo_bit;

  // Output register
  logic         out_valid_r;
  plqm_result_t out_r;
  plqm_result_t res;
  logic [6:0]   pct;

  logic        in_xfer;
  logic [1:0]  op;
  logic [7:0]  rmagic, rkind;
  logic [15:0] rseq;
  logic [10:0] elapsed_inc;
  logic        reply_good;
  logic        out_load;

  assign op     = in_tuser;
  assign rmagic = in_tdata[7:0];
  assign rkind  = in_tdata[15:8];
  assign rseq   = in_tdata[31:16];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r};
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Per-item state update
  always_comb begin
    uptime_nxt   = uptime_r;
    since_nxt    = since_r;
    open_nxt     = open_r;
    elapsed_nxt  = elapsed_r;
    seq_nxt      = seq_r;
    acc_seq_nxt  = acc_seq_r;
    sent_nxt     = sent_r;
    ok_nxt       = ok_r;
    lat_last_nxt = lat_last_r;
    lat_best_nxt = lat_best_r;
    send_nxt     = 1'b0;
    pseq_nxt     = 16'd0;
    pup_nxt      = 32'd0;
    rok_nxt      = 1'b0;
    elapsed_inc  = {1'b0, elapsed_r} + 11'd1;
    reply_good   = open_r && (rmagic == magic_r) && (rkind == REPLY_KIND) &&
                   ((rseq == seq_r) || (rseq != acc_seq_r));
    unique case (op)
      OP_TICK: begin
        uptime_nxt = uptime_r + 32'd1;
        if (since_r != SINCE_SAT) since_nxt = since_r + 16'd1;
        if (open_r) begin
          elapsed_nxt = elapsed_inc[9:0];
          if (elapsed_inc >= {1'b0, window_r}) open_nxt = 1'b0;
        end else if (since_nxt >= period_r) begin
          seq_nxt     = seq_r + 16'd1;
          since_nxt   = 16'd0;
          if (sent_r != CNT_SAT) sent_nxt = sent_r + 32'd1;
          open_nxt    = 1'b1;
          elapsed_nxt = 10'd0;
          send_nxt    = 1'b1;
          pseq_nxt    = seq_r + 16'd1;
          pup_nxt     = uptime_r + 32'd1;
        end
      end
      OP_REPLY: begin
        if (reply_good) begin
          if (ok_r != CNT_SAT) ok_nxt = ok_r + 32'd1;
          acc_seq_nxt  = rseq;
          lat_last_nxt = elapsed_r;
          if ((lat_best_r == 10'd0) || (elapsed_r < lat_best_r)) lat_best_nxt = elapsed_r;
          open_nxt     = 1'b0;
          rok_nxt      = 1'b1;
        end
      end
      OP_CLEAR: begin
        since_nxt    = SINCE_SAT;
        open_nxt     = 1'b0;
        elapsed_nxt  = 10'd0;
        seq_nxt      = 16'd0;
        acc_seq_nxt  = 16'd0;
        sent_nxt     = 32'd0;
        ok_nxt       = 32'd0;
        lat_last_nxt = 10'd0;
        lat_best_nxt = 10'd0;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // One restoring division step
  always_comb begin
    rem_shift = {rem_r, num_r[DIVIDEND_W-1]};
    rem_diff  = rem_shift - {1'b0, sent_r};
    quo_bit   = !rem_diff[32];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == DIV_LAST) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result assembly with clamp and empty-count case
  always_comb begin
    if (sent_r == 32'd0) pct = 7'd0;
    else if (ovf_r || (quo_r > PCT_SCALE)) pct = PCT_SCALE;
    else pct = quo_r;
    res.ping_send    = send_r;
    res.ping_seq     = pseq_r;
    res.ping_uptime  = pup_r;
    res.reply_ok     = rok_r;
    res.waiting      = open_r;
    res.sent_total   = sent_r;
    res.ok_total     = ok_r;
    res.latency_last = lat_last_r;
    res.latency_best = lat_best_r;
    res.quality_pct  = pct;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      period_r    <= PERIOD_RESET;
      window_r    <= WINDOW_RESET;
      magic_r     <= MAGIC_RESET;
      uptime_r    <= 32'd0;
      since_r     <= SINCE_SAT;
      open_r      <= 1'b0;
      elapsed_r   <= 10'd0;
      seq_r       <= 16'd0;
      acc_seq_r   <= 16'd0;
      sent_r      <= 32'd0;
      ok_r        <= 32'd0;
      lat_last_r  <= 10'd0;
      lat_best_r  <= 10'd0;
      cnt_r       <= 6'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SEND_PERIOD: period_r <= cfg_data;
          CFG_WAIT_WINDOW: window_r <= cfg_data[9:0];
          CFG_MAGIC:       magic_r  <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        uptime_r   <= uptime_nxt;
        since_r    <= since_nxt;
        open_r     <= open_nxt;
        elapsed_r  <= elapsed_nxt;
        seq_r      <= seq_nxt;
        acc_seq_r  <= acc_seq_nxt;
        sent_r     <= sent_nxt;
        ok_r       <= ok_nxt;
        lat_last_r <= lat_last_nxt;
        lat_best_r <= lat_best_nxt;
      end
      if (state_r == ST_LOAD) cnt_r <= 6'd0;
      else if (state_r == ST_DIV) cnt_r <= cnt_r + 6'd1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      send_r <= send_nxt;
      pseq_r <= pseq_nxt;
      pup_r  <= pup_nxt;
      rok_r  <= rok_nxt;
    end
    // ok*100 as ok*64 + ok*32 + ok*4
    if (state_r == ST_LOAD) begin
      num_r <= ({7'd0, ok_r} << 6) + ({7'd0, ok_r} << 5) + ({7'd0, ok_r} << 2);
      rem_r <= 32'd0;
      quo_r <= 7'd0;
      ovf_r <= 1'b0;
    end else if (state_r == ST_DIV) begin
      num_r <= {num_r[DIVIDEND_W-2:0], 1'b0};
      rem_r <= quo_bit ? rem_diff[31:0] : rem_shift[31:0];
      quo_r <= {quo_r[5:0], quo_bit};
      ovf_r <= ovf_r | quo_r[6];
    end
    if (out_load) out_r <= res;
  end

endmodule
`default_nettype wire

[verif/ping_link_quality_monitor_unit_test.sv]
`timescale 1ns / 100ps

module ping_link_quality_monitor_unit_test;
  import plqm_pkg::*;

  localparam int unsigned IDLE_LIMIT = 3000;

  // Link monitor predictor plus the queue of status words still owed by the block
  class plqm_scoreboard;
    logic [15:0] period_ms;
    logic [9:0]  window_ms;
    logic [7:0]  magic;
    logic [31:0] uptime;
    logic [15:0] since_send;
    bit          win_open;
    int unsigned elapsed;
    logic [15:0] last_seq;
    logic [15:0] acc_seq;
    logic [31:0] sent_cnt;
    logic [31:0] ok_cnt;
    logic [9:0]  lat_last;
    logic [9:0]  lat_best;
    plqm_result_t pending[$];
    int unsigned checked, mismatches, pings, oks, clears;

    function new();
      period_ms = PERIOD_RESET;
      window_ms = WINDOW_RESET;
      magic     = MAGIC_RESET;
      uptime    = '0;
      clear_stats();
    endfunction

    function void clear_stats();
      since_send = SINCE_SAT;
      win_open   = 1'b0;
      elapsed    = 0;
      last_seq   = '0;
      acc_seq    = '0;
      sent_cnt   = '0;
      ok_cnt     = '0;
      lat_last   = '0;
      lat_best   = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_SEND_PERIOD: period_ms = val;
        CFG_WAIT_WINDOW: window_ms = val[9:0];
        CFG_MAGIC:       magic     = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == CNT_SAT) ? v : v + 32'd1;
    endfunction

    // Apply one accepted input transfer and queue the status word it must produce
    function plqm_result_t note_input(logic [1:0] op, logic [7:0] rmagic,
                                      logic [7:0] rkind, logic [15:0] rseq);
      plqm_result_t r;
      logic [63:0] q;
      r = '0;
      case (op)
        OP_TICK: begin
          uptime = uptime + 32'd1;
          if (since_send != SINCE_SAT) since_send = since_send + 16'd1;
          if (win_open) begin
            elapsed++;
            if (elapsed >= window_ms) win_open = 1'b0;
          end else if (since_send >= period_ms) begin
            last_seq      = last_seq + 16'd1;
            since_send    = '0;
            sent_cnt      = bump(sent_cnt);
            win_open      = 1'b1;
            elapsed       = 0;
            r.ping_send   = 1'b1;
            r.ping_seq    = last_seq;
            r.ping_uptime = uptime;
            pings++;
          end
        end
        OP_REPLY: begin
          if (win_open && rmagic == magic && rkind == REPLY_KIND &&
              (rseq == last_seq || rseq != acc_seq)) begin
            ok_cnt   = bump(ok_cnt);
            acc_seq  = rseq;
            lat_last = elapsed[9:0];
            // zero latency leaves the best value unset
            if (lat_best == '0 || lat_last < lat_best) lat_best = lat_last;
            win_open   = 1'b0;
            r.reply_ok = 1'b1;
            oks++;
          end
        end
        OP_CLEAR: begin
          clear_stats();
          clears++;
        end
        default: ;
      endcase
      r.waiting      = win_open;
      r.sent_total   = sent_cnt;
      r.ok_total     = ok_cnt;
      r.latency_last = lat_last;
      r.latency_best = lat_best;
      if (sent_cnt == '0) begin
        r.quality_pct = '0;
      end else begin
        q = (64'(ok_cnt) * 64'(PCT_SCALE)) / 64'(sent_cnt);
        r.quality_pct = (q > 64'(PCT_SCALE)) ? PCT_SCALE : q[6:0];
      end
      pending.push_back(r);
      return r;
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one status transfer against the oldest queued prediction
    function void check_result(logic [143:0] td);
      plqm_result_t got, want;
      got = td[141:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, td);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      cmp("ping_send",    want.ping_send,    got.ping_send);
      cmp("ping_seq",     want.ping_seq,     got.ping_seq);
      cmp("ping_uptime",  want.ping_uptime,  got.ping_uptime);
      cmp("reply_ok",     want.reply_ok,     got.reply_ok);
      cmp("waiting",      want.waiting,      got.waiting);
      cmp("sent_total",   want.sent_total,   got.sent_total);
      cmp("ok_total",     want.ok_total,     got.ok_total);
      cmp("latency_last", want.latency_last, got.latency_last);
      cmp("latency_best", want.latency_best, got.latency_best);
      cmp("quality_pct",  want.quality_pct,  got.quality_pct);
      cmp("pad",          32'd0,             td[143:142]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  plqm_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned reply_due = 0;
  int unsigned counted = 0;
  int unsigned in_xfers = 0;
  int unsigned settings = 1;
  int unsigned idle_cycles = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_phase = 0;

  ping_link_quality_monitor_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Result side: check each transfer, stall on a changing pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 400);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rx_phase % 50) >= 30;
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL ping_link_quality_monitor_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic cfg_xfer(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Write all three registers back to back, valid held high across them
  task automatic cfg_set(input logic [15:0] period, input logic [9:0] win,
                         input logic [7:0] mgc);
    cfg_xfer(CFG_SEND_PERIOD, period);
    cfg_xfer(CFG_WAIT_WINDOW, {6'd0, win});
    cfg_xfer(CFG_MAGIC, {8'd0, mgc});
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Let every outstanding status word arrive before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One input transfer, with sender bursts and gaps
  task automatic drive_item(input logic [1:0] op, input logic [7:0] m,
                            input logic [7:0] k, input logic [15:0] s);
    plqm_result_t r;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {s, k, m};
    do @(posedge clk); while (!in_tready);
    in_xfers++;
    r = sb.note_input(op, m, k, s);
    if (op == OP_TICK || op == OP_CLEAR || r.reply_ok) counted++;
    // pick the latency at which the next reply shows up
    if (r.ping_send) begin
      if ($urandom_range(0, 1))
        reply_due = $urandom_range(0, 6);
      else
        reply_due = $urandom_range(0, int'(sb.window_ms) + int'(sb.window_ms) / 4);
    end
  endtask

  // Mostly ticks with well-formed replies at the chosen latency, plus noise
  task automatic random_item(input int unsigned clear_pm);
    int unsigned r;
    logic [7:0]  m, k;
    logic [15:0] s;
    r = $urandom_range(0, 999);
    m = 8'($urandom);
    k = 8'($urandom);
    s = 16'($urandom);
    if (r < clear_pm) begin
      drive_item(OP_CLEAR, m, k, s);
    end else if (r < clear_pm + 15) begin
      drive_item(OP_NONE, m, k, s);
    end else if (r < clear_pm + 55) begin
      drive_item(OP_REPLY, m, k, s);
    end else if (sb.win_open && sb.elapsed >= reply_due) begin
      m = sb.magic;
      k = REPLY_KIND;
      s = sb.last_seq;
      case ($urandom_range(0, 9))
        0: m = sb.magic ^ 8'($urandom_range(1, 255));
        1: k = REPLY_KIND ^ 8'($urandom_range(1, 255));
        2: s = sb.acc_seq;
        3: s = 16'($urandom);
        default: ;
      endcase
      drive_item(OP_REPLY, m, k, s);
    end else begin
      drive_item(OP_TICK, m, k, s);
    end
  endtask

  task automatic run_phase(input logic [15:0] period, input logic [9:0] win,
                           input logic [7:0] mgc, input int unsigned n,
                           input int unsigned clear_pm);
    drain();
    cfg_set(period, win, mgc);
    counted = 0;
    while (counted < n) random_item(clear_pm);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings
    drive_item(OP_NONE, 8'hFF, 8'hFF, 16'hFFFF);
    drive_item(OP_REPLY, MAGIC_RESET, REPLY_KIND, 16'd1);   // no window open
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);            // first tick pings
    drive_item(OP_REPLY, 8'h00, REPLY_KIND, 16'd1);         // bad magic
    drive_item(OP_REPLY, MAGIC_RESET, 8'hFD, 16'd1);        // bad kind
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);
    drive_item(OP_REPLY, MAGIC_RESET, REPLY_KIND, 16'd1);   // accepted
    drive_item(OP_REPLY, MAGIC_RESET, REPLY_KIND, 16'd1);   // window already closed
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);
    drive_item(OP_CLEAR, 8'hFF, 8'hFF, 16'hFFFF);
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);            // pings right after clear
    drive_item(OP_REPLY, MAGIC_RESET, REPLY_KIND, 16'hFFFF); // accepted, best latency stays unset

    // Directed: zero period, zero window, all-ones magic
    drain();
    cfg_set(16'd0, 10'd0, 8'hFF);
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);            // window closes at once
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);
    drive_item(OP_REPLY, 8'hFF, REPLY_KIND, 16'hFFFF);      // repeats accepted seq
    drive_item(OP_REPLY, 8'hFF, REPLY_KIND, 16'h0000);      // differs from accepted
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);
    drive_item(OP_REPLY, 8'hFF, REPLY_KIND, 16'd5);         // differs from accepted
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);
    drive_item(OP_REPLY, 8'hFF, REPLY_KIND, 16'd6);
    drive_item(OP_TICK, 8'h00, 8'h00, 16'h0000);

    // Random phases over several register settings
    run_phase(16'd1,     10'd1,    8'h00, 175, 10);
    run_phase(16'd0,     10'd0,    8'hFF, 130, 10);
    run_phase(16'd7,     10'd20,   8'h5A, 260, 10);
    run_phase(16'd65535, 10'd1023, 8'hB4, 130, 40);
    run_phase(16'd3,     10'd1023, 8'hA5, 390, 2);
    run_phase(16'd20,    10'd60,   8'h3C, 130, 10);

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Run covered %0d input transfers over %0d register settings, %0d results checked",
             in_xfers, settings, sb.checked);
    $display("Pings %0d, replies accepted %0d, clears %0d, mismatches %0d",
             sb.pings, sb.oks, sb.clears, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS ping_link_quality_monitor_unit");
    end else begin
      $display("FAIL ping_link_quality_monitor_unit");
    end
    $finish;
  end

endmodule

[ping_link_quality_monitor_unit.f]
src/plqm_pkg.sv
src/ping_link_quality_monitor_unit.sv
verif/ping_link_quality_monitor_unit_test.sv
